// ----- sv/fra_pkg.sv -----
// shared types, codes and constants for the fenced ring allocator
// no dependencies; every other file but fra_ram imports this package
package fra_pkg;

  localparam int SEG_SLOTS_DEF = 16;
  localparam int ADDR_BITS     = 20;
  localparam int RING_W        = 21;
  localparam int OFFS_W        = 20;
  localparam int SLOT_ID_W     = 4;
  localparam int REQ_TYPE_W    = 2;
  localparam int STATUS_W      = 3;
  localparam int SEG_START_W   = (ADDR_BITS < RING_W) ? ADDR_BITS : RING_W;

  // largest usable ring, as a value one bit wider than the ring register
  localparam logic [RING_W:0] RING_CAP = (ADDR_BITS < RING_W) ?
      ((RING_W + 1)'(1) << ADDR_BITS) : ((RING_W + 1)'(1) << RING_W);
  localparam logic [RING_W-1:0] RING_RESET = RING_W'(65536);

  localparam logic [REQ_TYPE_W-1:0] REQ_RESERVE = REQ_TYPE_W'(0);
  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT  = REQ_TYPE_W'(1);
  localparam logic [REQ_TYPE_W-1:0] REQ_SIGNAL  = REQ_TYPE_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 3'd0,
    STS_ZERO_SIZE  = 3'd1,
    STS_NO_SPACE   = 3'd2,
    STS_NO_CONTIG  = 3'd3,
    STS_QUEUE_FULL = 3'd4,
    STS_NOT_LIVE   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_RESERVE,
    OP_ZERO,
    OP_INSERT,
    OP_SIGNAL,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [RING_W-1:0]      bytes;
    logic [SLOT_ID_W-1:0]   slot;
    logic                   slot_in_range;
  } cmd_t;

  typedef struct packed {
    logic                start;
    logic [RING_W:0]     value;
    logic [RING_W-1:0]   modulus;
  } mod_req_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_RET_EVAL,
    B_RET_WAIT,
    B_RETRY,
    B_MOD,
    B_PUT
  } back_state_t;

endpackage

// ----- sv/fra_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module fra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fra_front.sv -----
// front end: classifies request beats and holds them in a two-entry queue
// depends on fra_pkg
module fra_front import fra_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [REQ_TYPE_W-1:0] req_type,
  input  logic [RING_W-1:0]     req_bytes,
  input  logic [SLOT_ID_W-1:0]  slot_id,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t       cls;
  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;

  // classify the incoming beat
  always_comb begin
    cls.bytes         = req_bytes;
    cls.slot          = slot_id;
    cls.slot_in_range = (32'(slot_id) < SEG_SLOTS);
    unique case (req_type)
      REQ_RESERVE: cls.op = (req_bytes == '0) ? OP_ZERO : OP_RESERVE;
      REQ_INSERT:  cls.op = OP_INSERT;
      REQ_SIGNAL:  cls.op = OP_SIGNAL;
      default:     cls.op = OP_BAD;
    endcase
  end

  assign req_stall = (cnt == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      unique case ({push, cmd_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- sv/fra_mod.sv -----
// bit-serial remainder unit, one quotient bit per cycle
// depends on fra_pkg
module fra_mod import fra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mod_req_t          req,
  output logic              done,
  output logic [RING_W-1:0] rem
);

  localparam int STEPS = RING_W + 1;
  localparam int CW    = $clog2(STEPS + 1);

  logic [RING_W:0]   val;
  logic [RING_W-1:0] modulus;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [RING_W:0]   trial;
  logic [RING_W:0]   diff;
  logic [RING_W-1:0] rem_next;

  always_comb begin
    trial = {rem, val[RING_W]};
    diff  = trial - {1'b0, modulus};
    if (trial >= {1'b0, modulus}) begin
      rem_next = diff[RING_W-1:0];
    end else begin
      rem_next = trial[RING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val     <= req.value;
      modulus <= req.modulus;
      rem     <= '0;
    end else if (busy) begin
      val <= val << 1;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CW'(STEPS);
      done <= 1'b0;
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= (cnt != CW'(1));
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ----- sv/fra_back.sv -----
// back end: executes classified commands against the ring and segment queue
// depends on fra_pkg, fra_ram and fra_mod
module fra_back import fra_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [RING_W-1:0]    cfg_wdata,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 ok,
  output logic [STATUS_W-1:0]  status,
  output logic [OFFS_W-1:0]    alloc_offset,
  output logic [SLOT_ID_W-1:0] alloc_slot,
  output logic [RING_W-1:0]    used_bytes
);

  localparam int SLOT_W = $clog2(SEG_SLOTS);
  localparam int CNT_W  = $clog2(SEG_SLOTS + 1);
  localparam int SEG_W  = SEG_START_W + RING_W;

  function automatic logic [RING_W-1:0] cap_ring(input logic [RING_W-1:0] v);
    if ({1'b0, v} > RING_CAP) begin
      return RING_CAP[RING_W-1:0];
    end
    return v;
  endfunction

  back_state_t state, state_next;

  logic [RING_W-1:0] ring_eff;
  logic [RING_W-1:0] head;
  logic [RING_W-1:0] tail;
  logic [RING_W-1:0] used;
  logic [SLOT_W-1:0] rd_ptr;
  logic [SLOT_W-1:0] wr_ptr;
  logic [CNT_W-1:0]  count;

  cmd_t                 cur;
  logic                 res_ok;
  status_t              res_status;
  logic [OFFS_W-1:0]    res_offs;
  logic [SLOT_ID_W-1:0] res_slot;
  logic                 wrap_to_tail;

  // segment memories
  logic             seg_we;
  logic [SEG_W-1:0] seg_wdata;
  logic [SEG_W-1:0] seg_rdata;
  logic             ins_we;
  logic             ins_wd;
  logic             ins_rd;
  logic             sig_we;
  logic             sig_wd;
  logic             sig_rd;
  logic [SLOT_W-1:0] flag_addr;

  logic [RING_W-1:0]      rd_start;
  logic [RING_W-1:0]      rd_len;
  logic [31:0]            slot_wide;
  logic [31:0]            wr_wide;
  logic [SLOT_W-1:0]      slot_idx;
  logic [SLOT_W:0]        slot_dist;
  logic                   live;

  logic [RING_W-1:0] free_sp;
  logic [RING_W-1:0] contig;
  logic              tail_ge_head;
  logic              fit_tail;
  logic              fits;
  logic [RING_W-1:0] where;
  logic              full;
  logic              first_ok;
  logic              do_place;
  logic              retire_blocked;
  logic              do_retire;

  logic [RING_W:0]   wrap_v;
  logic [RING_W:0]   wrap_diff;
  logic [RING_W:0]   ring_ext;
  logic              wrap_fast;
  logic [RING_W-1:0] wrap_val;

  mod_req_t          mod_req;
  logic              mod_done;
  logic [RING_W-1:0] mod_rem;
  logic              out_free;

  fra_ram #(.WIDTH(SEG_W), .DEPTH(SEG_SLOTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (wr_ptr),
    .wdata (seg_wdata),
    .raddr (rd_ptr),
    .rdata (seg_rdata)
  );

  fra_ram #(.WIDTH(1), .DEPTH(SEG_SLOTS)) u_ins_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (flag_addr),
    .wdata (ins_wd),
    .raddr (rd_ptr),
    .rdata (ins_rd)
  );

  fra_ram #(.WIDTH(1), .DEPTH(SEG_SLOTS)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (flag_addr),
    .wdata (sig_wd),
    .raddr (rd_ptr),
    .rdata (sig_rd)
  );

  fra_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  assign rd_start  = RING_W'(seg_rdata[SEG_W-1:RING_W]);
  assign rd_len    = seg_rdata[RING_W-1:0];
  assign seg_wdata = {where[SEG_START_W-1:0], cur.bytes};
  assign slot_wide = 32'(cur.slot);
  assign slot_idx  = slot_wide[SLOT_W-1:0];
  assign wr_wide   = 32'(wr_ptr);
  assign out_free  = !rsp_valid || !rsp_stall;

  // slot liveness: distance from the read pointer below the fill count
  always_comb begin
    if (slot_idx >= rd_ptr) begin
      slot_dist = {1'b0, slot_idx} - {1'b0, rd_ptr};
    end else begin
      slot_dist = {1'b0, slot_idx} + (SLOT_W + 1)'(SEG_SLOTS) - {1'b0, rd_ptr};
    end
    live = cur.slot_in_range && (32'(slot_dist) < 32'(count));
  end

  // placement decision from the current ring state
  always_comb begin
    free_sp      = (used >= ring_eff) ? '0 : ring_eff - used;
    tail_ge_head = (tail >= head);
    if (tail_ge_head) begin
      contig = (tail >= ring_eff) ? '0 : ring_eff - tail;
    end else begin
      contig = head - tail;
    end
    fit_tail = (contig >= cur.bytes);
    fits     = (free_sp >= cur.bytes) &&
               (fit_tail || (tail_ge_head && head >= cur.bytes));
    where    = fit_tail ? tail : '0;
    full     = (count == CNT_W'(SEG_SLOTS));
    first_ok = !full && fits;
    do_place = ((state == B_EXEC) && (cur.op == OP_RESERVE) && first_ok) ||
               ((state == B_RETRY) && fits && !full);
    retire_blocked = (count == '0) || (ins_rd && !sig_rd);
    do_retire      = (state == B_RET_EVAL) && !retire_blocked;
  end

  // offset wrap; fast when the value is below twice the ring
  always_comb begin
    if (do_retire) begin
      wrap_v = {1'b0, rd_start} + {1'b0, rd_len};
    end else begin
      wrap_v = {1'b0, where} + {1'b0, cur.bytes};
    end
    ring_ext  = {1'b0, ring_eff};
    wrap_diff = wrap_v - ring_ext;
    wrap_fast = 1'b1;
    wrap_val  = '0;
    if (ring_eff == '0) begin
      wrap_val = '0;
    end else if (wrap_v < ring_ext) begin
      wrap_val = wrap_v[RING_W-1:0];
    end else if (wrap_diff < ring_ext) begin
      wrap_val = wrap_diff[RING_W-1:0];
    end else begin
      wrap_fast = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cur.op == OP_RESERVE) begin
          if (first_ok) begin
            state_next = wrap_fast ? B_PUT : B_MOD;
          end else begin
            state_next = B_RET_EVAL;
          end
        end else begin
          state_next = B_PUT;
        end
      end
      B_RET_EVAL: begin
        if (retire_blocked) begin
          state_next = B_RETRY;
        end else begin
          state_next = wrap_fast ? B_RET_WAIT : B_MOD;
        end
      end
      B_RET_WAIT: state_next = B_RET_EVAL;
      B_RETRY: begin
        if (do_place && !wrap_fast) begin
          state_next = B_MOD;
        end else begin
          state_next = B_PUT;
        end
      end
      B_MOD: begin
        if (mod_done) begin
          state_next = wrap_to_tail ? B_PUT : B_RET_WAIT;
        end
      end
      B_PUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    cmd_pop   = (state == B_IDLE) && cmd_valid;
    seg_we    = do_place;
    flag_addr = do_place ? wr_ptr : slot_idx;
    ins_we    = do_place || ((state == B_EXEC) && (cur.op == OP_INSERT) && live);
    sig_we    = do_place || ((state == B_EXEC) && (cur.op == OP_SIGNAL) && live);
    ins_wd    = !do_place;
    sig_wd    = !do_place;
    mod_req.start   = (do_place || do_retire) && !wrap_fast;
    mod_req.value   = wrap_v;
    mod_req.modulus = ring_eff;
  end

  // control and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      ring_eff  <= cap_ring(RING_RESET);
      head      <= '0;
      tail      <= '0;
      used      <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ring_eff <= cap_ring(cfg_wdata);
      end
      if (do_place) begin
        wr_ptr <= (wr_ptr == SLOT_W'(SEG_SLOTS - 1)) ? '0 : wr_ptr + SLOT_W'(1);
        count  <= count + CNT_W'(1);
        used   <= used + cur.bytes;
        if (wrap_fast) begin
          tail <= wrap_val;
        end
      end
      if (do_retire) begin
        used   <= (used >= rd_len) ? used - rd_len : '0;
        rd_ptr <= (rd_ptr == SLOT_W'(SEG_SLOTS - 1)) ? '0 : rd_ptr + SLOT_W'(1);
        count  <= count - CNT_W'(1);
        if (wrap_fast) begin
          head <= wrap_val;
        end
      end
      if ((state == B_RET_EVAL) && (count == '0)) begin
        head <= '0;
        tail <= '0;
      end
      if ((state == B_MOD) && mod_done) begin
        if (wrap_to_tail) begin
          tail <= mod_rem;
        end else begin
          head <= mod_rem;
        end
      end
      if ((state == B_PUT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (do_place) begin
      wrap_to_tail <= 1'b1;
    end else if (do_retire) begin
      wrap_to_tail <= 1'b0;
    end
    if (do_place) begin
      res_ok     <= 1'b1;
      res_status <= STS_OK;
      res_offs   <= where[OFFS_W-1:0];
      res_slot   <= wr_wide[SLOT_ID_W-1:0];
    end else if (state == B_EXEC) begin
      res_offs <= '0;
      res_slot <= '0;
      unique case (cur.op)
        OP_ZERO: begin
          res_ok     <= 1'b0;
          res_status <= STS_ZERO_SIZE;
        end
        OP_INSERT, OP_SIGNAL: begin
          res_ok     <= live;
          res_status <= live ? STS_OK : STS_NOT_LIVE;
        end
        default: begin
          res_ok     <= 1'b0;
          res_status <= STS_NOT_LIVE;
        end
      endcase
    end else if (state == B_RETRY) begin
      res_ok   <= 1'b0;
      res_offs <= '0;
      res_slot <= '0;
      priority if (free_sp < cur.bytes) begin
        res_status <= STS_NO_SPACE;
      end else if (!fits) begin
        res_status <= STS_NO_CONTIG;
      end else begin
        res_status <= STS_QUEUE_FULL;
      end
    end
    if ((state == B_PUT) && out_free) begin
      ok           <= res_ok;
      status       <= res_status;
      alloc_offset <= res_offs;
      alloc_slot   <= res_slot;
      used_bytes   <= used;
    end
  end

endmodule

// ----- sv/fenced_ring_allocator.sv -----
// path: a request beat goes through the front queue, then the back end states idle, exec
//   and put, then the result register; a miss adds the retire loop (ret_eval and ret_wait
//   per retired segment, memory read) and a retry, and a wrap past twice the ring (only
//   after a shrink) adds the bit-serial remainder; one command is in the back end at a time
// reset: synchronous, clears offsets, pointers, counts and sets the ring to
//   65536 bytes; the segment memories are not cleared
module fenced_ring_allocator import fra_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: ring size in bytes
  input  logic                  cfg_we,
  input  logic [RING_W-1:0]     cfg_wdata,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [REQ_TYPE_W-1:0] req_type,
  input  logic [RING_W-1:0]     req_bytes,
  input  logic [SLOT_ID_W-1:0]  slot_id,
  // result channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  ok,
  output logic [STATUS_W-1:0]   status,
  output logic [OFFS_W-1:0]     alloc_offset,
  output logic [SLOT_ID_W-1:0]  alloc_slot,
  output logic [RING_W-1:0]     used_bytes
);

  // front classifies each request beat (reserve, zero size, fence insert,
  // fence signal, unknown) and parks it in a two-entry queue, so a new beat
  // is taken while the back end still works or while a result waits
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  fra_front #(.SEG_SLOTS(SEG_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .req_bytes (req_bytes),
    .slot_id   (slot_id),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back end holds the ring offsets and the segment fifo; a reserve that
  // misses retires finished segments from the head one at a time, then
  // tries once more; the result sits in an output register until taken
  fra_back #(.SEG_SLOTS(SEG_SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .status       (status),
    .alloc_offset (alloc_offset),
    .alloc_slot   (alloc_slot),
    .used_bytes   (used_bytes)
  );

`ifndef SYNTHESIS
  // the back end never pops an empty queue
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // success and status agree on every result beat
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && ok) |-> (status == STS_OK))
    else $error("ok result with failure status");

  a_fail_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (status != STS_OK))
    else $error("failed result with ok status");

  // a nonzero offset only comes from a placed segment
  a_offset_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (alloc_offset != '0)) |-> ok)
    else $error("offset reported on a failed request");
`endif

endmodule

// ----- tb/ring_alloc_checker.sv -----
`timescale 1ns / 1ps
// result checker for the fenced ring allocator: follows the ring size register
// and both channels, predicts every result beat and compares it field by field
// depends on fra_pkg only
module ring_alloc_checker import fra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RING_W-1:0]     cfg_wdata,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic [REQ_TYPE_W-1:0] req_type,
  input  logic [RING_W-1:0]     req_bytes,
  input  logic [SLOT_ID_W-1:0]  slot_id,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic                  ok,
  input  logic [STATUS_W-1:0]   status,
  input  logic [OFFS_W-1:0]     alloc_offset,
  input  logic [SLOT_ID_W-1:0]  alloc_slot,
  input  logic [RING_W-1:0]     used_bytes,
  output int                    grants_owed,
  output int                    mismatches
);
  localparam int NSLOT      = SEG_SLOTS_DEF;
  localparam int REPORT_MAX = 10;
  localparam int OWED_DEPTH = 8;
  localparam int OWED_W     = 3;

  typedef struct packed {
    logic                 ok;
    status_t              st;
    logic [OFFS_W-1:0]    offs;
    logic [SLOT_ID_W-1:0] slot;
    logic [RING_W-1:0]    used;
  } grant_t;

  // shadow of the allocator
  logic [RING_W-1:0]    ring_size;
  logic [RING_W-1:0]    head, tail, used;
  logic [OFFS_W-1:0]    seg_base  [NSLOT];
  logic [RING_W-1:0]    seg_len   [NSLOT];
  logic                 fence_in  [NSLOT];
  logic                 fence_sig [NSLOT];
  logic [SLOT_ID_W-1:0] rd_ptr, wr_ptr;
  logic [SLOT_ID_W:0]   live;
  // predicted beats still owed, oldest at owed_rd
  grant_t               owed [OWED_DEPTH];
  logic [OWED_W-1:0]    owed_rd, owed_wr;
  int                   owed_n;
  int                   bad;

  // usable ring, capped at the address space
  function automatic int unsigned span();
    return ({1'b0, ring_size} > RING_CAP) ? 32'(RING_CAP) : 32'(ring_size);
  endfunction

  function automatic int unsigned wrap(int unsigned v);
    int unsigned r;
    r = span();
    return (r == 0) ? 0 : v % r;
  endfunction

  function automatic int unsigned free_bytes();
    int unsigned r;
    r = span();
    return (used >= r) ? 0 : r - used;
  endfunction

  function automatic int unsigned run_at_tail();
    int unsigned r;
    r = span();
    if (tail >= head) return (tail >= r) ? 0 : r - tail;
    return head - tail;
  endfunction

  // room at the tail first, else at offset 0 when the tail is not behind the head
  function automatic bit fits(int unsigned size, output int unsigned where);
    where = 0;
    if (free_bytes() < size) return 1'b0;
    if (run_at_tail() >= size) begin
      where = tail;
      return 1'b1;
    end
    return (tail >= head && head >= size);
  endfunction

  // drop leading segments unless their fence is inserted and still pending
  function automatic void retire_done();
    while (live != 0 && !(fence_in[rd_ptr] && !fence_sig[rd_ptr])) begin
      used   = (used >= seg_len[rd_ptr]) ? used - seg_len[rd_ptr] : '0;
      head   = RING_W'(wrap(32'(seg_base[rd_ptr]) + 32'(seg_len[rd_ptr])));
      rd_ptr = rd_ptr + 1'b1;
      live   = live - 1'b1;
    end
    if (live == 0) begin
      head = '0;
      tail = '0;
    end
  endfunction

  function automatic logic [SLOT_ID_W-1:0] place_seg(int unsigned where, int unsigned size);
    logic [SLOT_ID_W-1:0] s;
    s            = wr_ptr;
    seg_base[s]  = OFFS_W'(where);
    seg_len[s]   = RING_W'(size);
    fence_in[s]  = 1'b0;
    fence_sig[s] = 1'b0;
    wr_ptr       = wr_ptr + 1'b1;
    live         = live + 1'b1;
    tail         = RING_W'(wrap(where + size));
    used         = used + RING_W'(size);
    return s;
  endfunction

  function automatic bit is_live(logic [SLOT_ID_W-1:0] slot);
    logic [SLOT_ID_W-1:0] gap;
    gap = slot - rd_ptr;
    return {1'b0, gap} < live;
  endfunction

  function automatic grant_t predict_grant(logic [REQ_TYPE_W-1:0] kind,
                                           logic [RING_W-1:0] bytes,
                                           logic [SLOT_ID_W-1:0] slot);
    grant_t      g;
    int unsigned where;
    bit          placed;
    g.ok   = 1'b0;
    g.st   = STS_OK;
    g.offs = '0;
    g.slot = '0;
    if (kind == REQ_RESERVE) begin
      if (bytes == 0) begin
        g.st = STS_ZERO_SIZE;
      end else begin
        placed = (live < NSLOT) && fits(bytes, where);
        if (!placed) begin
          // second chance after retiring finished segments
          retire_done();
          if (free_bytes() < bytes) g.st = STS_NO_SPACE;
          else if (!fits(bytes, where)) g.st = STS_NO_CONTIG;
          else if (live >= NSLOT) g.st = STS_QUEUE_FULL;
          else placed = 1'b1;
        end
        if (placed) begin
          g.slot = place_seg(where, bytes);
          g.offs = OFFS_W'(where);
          g.ok   = 1'b1;
        end
      end
    end else if (kind == REQ_INSERT || kind == REQ_SIGNAL) begin
      if (is_live(slot)) begin
        if (kind == REQ_INSERT) fence_in[slot] = 1'b1;
        else fence_sig[slot] = 1'b1;
        g.ok = 1'b1;
      end else begin
        g.st = STS_NOT_LIVE;
      end
    end else begin
      g.st = STS_NOT_LIVE;
    end
    g.used = used;
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    grant_t fresh;
    if (rst) begin
      ring_size = RING_RESET;
      head      = '0;
      tail      = '0;
      used      = '0;
      rd_ptr    = '0;
      wr_ptr    = '0;
      live      = '0;
      for (int i = 0; i < NSLOT; i++) begin
        seg_base[i]  = '0;
        seg_len[i]   = '0;
        fence_in[i]  = 1'b0;
        fence_sig[i] = 1'b0;
      end
      owed_rd = '0;
      owed_wr = '0;
      owed_n  = 0;
      bad     = 0;
    end else begin
      if (cfg_we) ring_size = cfg_wdata;
      if (rsp_valid && !rsp_stall) begin
        if (owed_n == 0) begin
          bad++;
          if (bad <= REPORT_MAX)
            $display("%0t: result beat with none outstanding: ok=%0d status=%0d",
                     $realtime, ok, status, " offset=%0d slot=%0d used=%0d",
                     alloc_offset, alloc_slot, used_bytes);
        end else begin
          want    = owed[owed_rd];
          owed_rd = owed_rd + 1'b1;
          owed_n--;
          if (ok !== want.ok || status !== want.st || alloc_offset !== want.offs ||
              alloc_slot !== want.slot || used_bytes !== want.used) begin
            bad++;
            if (bad <= REPORT_MAX)
              $display("%0t: mismatch, expected ok=%0d status=%0d offset=%0d slot=%0d",
                       $realtime, want.ok, want.st, want.offs, want.slot,
                       " used=%0d; got ok=%0d status=%0d offset=%0d slot=%0d used=%0d",
                       want.used, ok, status, alloc_offset, alloc_slot, used_bytes);
          end
        end
      end
      if (req_valid && !req_stall) begin
        fresh = predict_grant(req_type, req_bytes, slot_id);
        if (owed_n >= OWED_DEPTH) begin
          bad++;
          if (bad <= REPORT_MAX)
            $display("%0t: more request beats outstanding than the bench tracks",
                     $realtime);
        end else begin
          owed[owed_wr] = fresh;
          owed_wr       = owed_wr + 1'b1;
          owed_n++;
        end
      end
    end
    grants_owed <= owed_n;
    mismatches  <= bad;
  end

endmodule

// ----- tb/fenced_ring_allocator_tb.sv -----
`timescale 1ns / 1ps
// top of the fenced ring allocator bench: clock, reset, request and result
// traffic, ring size phases and the verdict; needs fra_pkg, the block and
// ring_alloc_checker
module fenced_ring_allocator_tb import fra_pkg::*; ();

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = REQ_TYPE_W'(3);
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 156;
  localparam int SETTLE      = 8;     // quiet cycles before a ring size write
  localparam int DRAIN       = 40;    // cycles watched after the last result
  localparam int HOLD_AFTER  = 400;   // result beats before the long back-pressure
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat before giving up

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [RING_W-1:0]     cfg_wdata;
  logic                  req_valid;
  logic                  req_stall;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [RING_W-1:0]     req_bytes;
  logic [SLOT_ID_W-1:0]  slot_id;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic                  ok;
  logic [STATUS_W-1:0]   status;
  logic [OFFS_W-1:0]     alloc_offset;
  logic [SLOT_ID_W-1:0]  alloc_slot;
  logic [RING_W-1:0]     used_bytes;
  int                    grants_owed;
  int                    mismatches;

  logic                  quiet_req   = 1'b0;
  logic                  quiet_rsp   = 1'b0;
  int                    rsp_beats   = 0;
  logic [SLOT_ID_W-1:0]  newest_slot = '0;

  fenced_ring_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .req_bytes    (req_bytes),
    .slot_id      (slot_id),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .status       (status),
    .alloc_offset (alloc_offset),
    .alloc_slot   (alloc_slot),
    .used_bytes   (used_bytes)
  );

  ring_alloc_checker grant_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .req_bytes    (req_bytes),
    .slot_id      (slot_id),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .status       (status),
    .alloc_offset (alloc_offset),
    .alloc_slot   (alloc_slot),
    .used_bytes   (used_bytes),
    .grants_owed  (grants_owed),
    .mismatches   (mismatches)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // reserve sizes scaled to the ring so that wrapping and fragmentation happen
  function automatic logic [RING_W-1:0] pick_bytes(logic [RING_W-1:0] ring);
    int unsigned eff;
    int          roll;
    eff  = ({1'b0, ring} > RING_CAP) ? 32'(RING_CAP) : 32'(ring);
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 9 || eff == 0) return RING_W'($urandom);
    if (roll < 15) return RING_W'($urandom_range(1, eff));
    if (roll < 18) return RING_W'(eff);
    return RING_W'($urandom_range(1, (eff > 8) ? eff / 6 : 1));
  endfunction

  // fence events mostly aim at recently granted slots, which are likely live
  function automatic logic [SLOT_ID_W-1:0] pick_slot();
    if ($urandom_range(0, 4) == 0) return SLOT_ID_W'($urandom);
    return newest_slot - SLOT_ID_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [RING_W-1:0] ring_for_phase(int p);
    case (p)
      1:       return RING_W'(4096);
      2:       return RING_W'(1);
      3:       return '0;
      4:       return '1;                  // beyond the address space
      5:       return RING_W'(RING_CAP);
      6:       return RING_W'(777);        // shrinks under live segments
      default: return RING_RESET;
    endcase
  endfunction

  // one request beat; returns on the falling edge after acceptance
  task automatic send_req(input logic [REQ_TYPE_W-1:0] kind,
                          input logic [RING_W-1:0]     bytes,
                          input logic [SLOT_ID_W-1:0]  slot);
    req_valid <= 1'b1;
    req_type  <= kind;
    req_bytes <= bytes;
    slot_id   <= slot;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // ring size changes only once every result is back
  task automatic set_ring(input logic [RING_W-1:0] value);
    req_valid <= 1'b0;
    while (grants_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result side bookkeeping for the stimulus
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      rsp_beats <= rsp_beats + 1;
      if (ok && (alloc_slot != '0 || alloc_offset != '0)) newest_slot <= alloc_slot;
    end
  end

  initial begin : stimulus
    logic [RING_W-1:0] ring_now;
    int                roll;
    int                gap;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req_type  = REQ_RESERVE;
    req_bytes = '0;
    slot_id   = '0;
    ring_now  = RING_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opening on the reset ring
    send_req(REQ_RESERVE, '0, '0);                      // zero size
    send_req(REQ_UNUSED, '1, '1);                       // undefined request type
    send_req(REQ_INSERT, '0, SLOT_ID_W'(5));            // fence on an empty queue
    for (int i = 0; i < SEG_SLOTS_DEF; i++)
      send_req(REQ_RESERVE, RING_W'(1), '0);            // fill every slot
    send_req(REQ_INSERT, '0, '0);                       // oldest segment now pins the queue
    send_req(REQ_RESERVE, RING_W'(1), '0);              // queue full
    send_req(REQ_SIGNAL, '0, SLOT_ID_W'(3));            // signal without insert
    send_req(REQ_RESERVE, '1, '1);                      // bigger than any ring
    send_req(REQ_SIGNAL, '0, '0);                       // releases the oldest segment
    send_req(REQ_RESERVE, RING_W'(RING_CAP), '0);       // whole address space, retires all

    // random phases over several ring sizes, some without any idling
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        ring_now = ring_for_phase(p);
        set_ring(ring_now);
      end
      quiet_req = (p == 2 || p == 5);
      quiet_rsp = (p == 3 || p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) send_req(REQ_RESERVE, pick_bytes(ring_now), SLOT_ID_W'($urandom));
        else if (roll < 70) send_req(REQ_INSERT, RING_W'($urandom), pick_slot());
        else if (roll < 93) send_req(REQ_SIGNAL, RING_W'($urandom), pick_slot());
        else send_req(REQ_UNUSED, RING_W'($urandom), SLOT_ID_W'($urandom));
        gap = quiet_req ? 0 : gap_len();
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    req_valid <= 1'b0;
    while (grants_owed != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side: random back-pressure, plus one long hold so the block fills up
  initial begin : receiver
    int   hold;
    logic squeezed;
    squeezed  = 1'b0;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = quiet_rsp ? 0 : gap_len();
      if (!squeezed && rsp_beats >= HOLD_AFTER) begin
        squeezed = 1'b1;
        hold     = HOLD_CYCLES;
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // gives up when no beat moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
